@@ rtl/core/mea_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mea_pkg
// Shared types and constants for the multi-entry alarm matcher.
// ----------------------------------------------------------------------------
package mea_pkg;

    // Default table depth.
    localparam int ALARM_ENTRIES_DEF = 16;

    // Event kinds carried in tuser.
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_BOOT   = 2'd1;
    localparam logic [1:0] KIND_RESUME = 2'd2;
    localparam logic [1:0] KIND_WRITE  = 2'd3;

    // Option word bit positions.
    localparam int OPT_ENABLE   = 0;
    localparam int OPT_HOUR12   = 1;
    localparam int OPT_BOOT     = 2;
    localparam int OPT_RESUME   = 3;
    localparam int OPT_INTERVAL = 4;
    localparam int OPT_BLINK    = 5;
    localparam int OPT_SOUND    = 6;
    localparam int OPT_REPEAT   = 7;
    localparam int OPT_HOURLY   = 8;
    localparam int OPT_RDELAY_LO = 9;
    localparam int OPT_IVAL_LO   = 25;
    localparam int OPT_BLINKS_LO = 41;

    // Timing constants in milliseconds and clock units.
    localparam logic [31:0] MS_PER_MIN  = 32'd60000;
    localparam logic [25:0] MS_PER_SEC  = 26'd1000;
    localparam logic [31:0] SUPPRESS_MS = 32'd60000;
    localparam logic [4:0]  HOURS_HALF  = 5'd12;
    localparam logic [4:0]  HOUR_PM1    = 5'd13;

    // Field widths.
    localparam int TDATA_IN_W  = 216;
    localparam int TDATA_OUT_W = 32;
    localparam int ENT_W       = 154;

    // One input word, unpacked.
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic [31:0] now_ms;
        logic [3:0]  entry_index;
        logic [23:0] hour_mask;
        logic [59:0] minute_mask;
        logic [6:0]  weekday_mask;
        logic [5:0]  match_second;
        logic [56:0] entry_options;
    } item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic write;
        logic start;
        logic read;
        logic mul;
        logic eval;
        logic flush;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_write;
        logic skip;
        logic walk_end;
        logic eval_stall;
        logic flush_done;
        logic hold_valid;
    } status_t;

endpackage

@@ rtl/core/mea_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mea_ctrl
// Sequencer that walks the alarm table one entry at a time.
// ----------------------------------------------------------------------------
module mea_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mea_pkg::status_t  status,
    output mea_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_EVAL  = 3'd5;
    localparam logic [2:0] ST_FLUSH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (status.is_write) begin
                    state_next = ST_WRITE;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = status.skip ? ST_IDLE : ST_READ;
                end
            end
            ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (!status.eval_stall) begin
                    state_next = status.walk_end ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH: begin
                cmd.flush = 1'b1;
                if (status.flush_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/mea_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mea_datapath
// Alarm table storage, per-entry match evaluation and result registers.
// ----------------------------------------------------------------------------
module mea_datapath #(
    parameter int ALARM_ENTRIES = mea_pkg::ALARM_ENTRIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mea_pkg::item_t                  item_in,
    input  mea_pkg::cmd_t                   cmd,
    output mea_pkg::status_t                status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mea_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic                            m_tlast
);

    localparam int IDX_W = (ALARM_ENTRIES > 1) ? $clog2(ALARM_ENTRIES) : 1;
    localparam int WID_W = IDX_W + 4;

    // Stored table and per-entry flags.
    logic [mea_pkg::ENT_W-1:0] ent_mem [ALARM_ENTRIES];
    logic [31:0]               lf_mem  [ALARM_ENTRIES];
    logic [ALARM_ENTRIES-1:0]  valid_reg;
    logic [ALARM_ENTRIES-1:0]  pend_reg;
    logic [ALARM_ENTRIES-1:0]  needs_reg;

    mea_pkg::item_t item_reg;
    logic [31:0]    resume_ms_reg;
    logic [4:0]     chk_hour_reg;
    logic [5:0]     chk_min_reg;
    logic [IDX_W-1:0] idx_reg;

    // Registered read data and second-stage values.
    logic [mea_pkg::ENT_W-1:0] rd_ent_reg;
    logic [31:0]               rd_lf_reg;
    logic [4:0]                h_reg;
    logic                      hit_h_reg;
    logic                      hit_m_reg;
    logic                      hit_w_reg;
    logic [25:0]               rlim_reg;
    logic [31:0]               ilim_reg;
    logic [31:0]               since_res_reg;
    logic [31:0]               since_fire_reg;

    // Pending result and output register.
    logic        hold_valid_reg;
    logic [3:0]  hold_idx_reg;
    logic        hold_blink_reg;
    logic [15:0] hold_bsec_reg;
    logic        hold_snd_reg;
    logic [5:0]  hold_loops_reg;
    logic        out_valid_reg;
    logic [3:0]  out_idx_reg;
    logic        out_blink_reg;
    logic [15:0] out_bsec_reg;
    logic        out_snd_reg;
    logic [5:0]  out_loops_reg;
    logic        out_last_reg;

    // Write address decode.
    logic [WID_W-1:0] wr_wide;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_in_range;
    logic             wr_en_opt;
    logic             wr_needs;
    logic [31:0]      wr_lf;

    assign wr_wide     = {{IDX_W{1'b0}}, item_reg.entry_index};
    assign wr_addr     = wr_wide[IDX_W-1:0];
    assign wr_in_range = (wr_wide < WID_W'(ALARM_ENTRIES));
    assign wr_en_opt   = item_reg.entry_options[mea_pkg::OPT_ENABLE];
    assign wr_needs    = wr_en_opt && ((item_reg.match_second != 6'd0)
                         || item_reg.entry_options[mea_pkg::OPT_INTERVAL]
                         || item_reg.entry_options[mea_pkg::OPT_RESUME]);
    assign wr_lf = (wr_en_opt && (item_reg.match_second == 6'd0)
                    && item_reg.entry_options[mea_pkg::OPT_INTERVAL]
                    && !item_reg.entry_options[mea_pkg::OPT_BOOT])
                   ? item_reg.now_ms : 32'd0;

    // Fields of the entry under evaluation.
    logic [23:0] e_hbits;
    logic [59:0] e_mbits;
    logic [6:0]  e_wbits;
    logic [5:0]  e_sec;
    logic [56:0] e_opt;
    logic [15:0] e_rdelay;
    logic [15:0] e_ival;

    assign e_hbits  = rd_ent_reg[23:0];
    assign e_mbits  = rd_ent_reg[83:24];
    assign e_wbits  = rd_ent_reg[90:84];
    assign e_sec    = rd_ent_reg[96:91];
    assign e_opt    = rd_ent_reg[153:97];
    assign e_rdelay = e_opt[mea_pkg::OPT_RDELAY_LO +: 16];
    assign e_ival   = e_opt[mea_pkg::OPT_IVAL_LO +: 16];

    // Hour conversion for the entry read last cycle.
    logic [4:0] h_conv;
    always_comb begin
        h_conv = item_reg.hour;
        if (e_opt[mea_pkg::OPT_HOUR12]) begin
            if (item_reg.hour == 5'd0) begin
                h_conv = mea_pkg::HOURS_HALF;
            end else if (item_reg.hour >= mea_pkg::HOUR_PM1) begin
                h_conv = item_reg.hour - mea_pkg::HOURS_HALF;
            end
        end
    end

    // Event qualification before the walk.
    logic is_tick;
    logic is_boot;
    logic is_resume;
    logic any_valid;
    logic need_sec;
    logic same_hm;

    assign is_tick   = (item_reg.kind == mea_pkg::KIND_TICK);
    assign is_boot   = (item_reg.kind == mea_pkg::KIND_BOOT);
    assign is_resume = (item_reg.kind == mea_pkg::KIND_RESUME);
    assign any_valid = |valid_reg;
    assign need_sec  = |(valid_reg & needs_reg);
    assign same_hm   = (chk_hour_reg == item_reg.hour) && (chk_min_reg == item_reg.minute);

    // Firing decision for the current entry.
    logic live;
    logic res_wait;
    logic fire_raw;
    logic pend_clr;
    logic fire;
    logic out_free;
    logic push_eval;
    logic push_flush;
    logic [5:0] loops;

    always_comb begin
        live     = valid_reg[idx_reg] && e_opt[mea_pkg::OPT_ENABLE];
        res_wait = is_resume && e_opt[mea_pkg::OPT_RESUME] && (e_rdelay != 16'd0);
        fire_raw = 1'b0;
        pend_clr = 1'b0;
        if (is_tick && hit_h_reg && hit_m_reg && hit_w_reg
            && ((e_sec == 6'd0) || (e_sec == item_reg.second))) begin
            fire_raw = 1'b1;
        end
        if (is_boot && e_opt[mea_pkg::OPT_BOOT]) begin
            fire_raw = 1'b1;
        end
        if (is_resume && e_opt[mea_pkg::OPT_RESUME] && (e_rdelay == 16'd0)) begin
            fire_raw = 1'b1;
            pend_clr = 1'b1;
        end
        if (is_tick && pend_reg[idx_reg] && (since_res_reg > 32'(rlim_reg))) begin
            fire_raw = 1'b1;
            pend_clr = 1'b1;
        end
        if (e_opt[mea_pkg::OPT_INTERVAL] && (e_ival != 16'd0) && hit_h_reg
            && hit_w_reg && (since_fire_reg > ilim_reg)) begin
            fire_raw = 1'b1;
        end
        fire = live && !res_wait && fire_raw
               && !(is_tick && (since_fire_reg < mea_pkg::SUPPRESS_MS));

        loops = 6'd0;
        if (e_opt[mea_pkg::OPT_SOUND]) begin
            loops = e_opt[mea_pkg::OPT_REPEAT] ? 6'h3F : 6'd0;
            if (e_opt[mea_pkg::OPT_HOURLY]) begin
                loops = {1'b0, h_reg};
            end
        end
    end

    assign out_free   = !out_valid_reg || m_tready;
    assign push_eval  = cmd.eval && fire && hold_valid_reg && out_free;
    assign push_flush = cmd.flush && hold_valid_reg && out_free;

    // Status toward the controller.
    always_comb begin
        status            = '0;
        status.is_write   = (item_reg.kind == mea_pkg::KIND_WRITE);
        status.skip       = !any_valid || (is_tick && !need_sec && same_hm);
        status.walk_end   = (idx_reg == IDX_W'(ALARM_ENTRIES - 1));
        status.eval_stall = fire && hold_valid_reg && !out_free;
        status.flush_done = !hold_valid_reg || out_free;
        status.hold_valid = hold_valid_reg;
    end

    // Table memories: one write port, registered read.
    always_ff @(posedge aclk) begin
        if (cmd.write && wr_in_range) begin
            ent_mem[wr_addr] <= {item_reg.entry_options, item_reg.match_second,
                                 item_reg.weekday_mask, item_reg.minute_mask,
                                 item_reg.hour_mask};
        end
        if (cmd.write && wr_in_range) begin
            lf_mem[wr_addr] <= wr_lf;
        end else if (cmd.eval && fire && !status.eval_stall) begin
            lf_mem[idx_reg] <= item_reg.now_ms;
        end
        if (cmd.read) begin
            rd_ent_reg <= ent_mem[idx_reg];
            rd_lf_reg  <= lf_mem[idx_reg];
        end
    end

    // Second stage: match bits, limits and elapsed times.
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            h_reg          <= h_conv;
            hit_h_reg      <= (h_conv < 5'd24) && e_hbits[h_conv];
            hit_m_reg      <= (item_reg.minute < 6'd60) && e_mbits[item_reg.minute];
            hit_w_reg      <= (item_reg.weekday < 3'd7) && e_wbits[item_reg.weekday];
            rlim_reg       <= 26'(e_rdelay) * mea_pkg::MS_PER_SEC;
            ilim_reg       <= 32'(e_ival) * mea_pkg::MS_PER_MIN;
            since_res_reg  <= item_reg.now_ms - resume_ms_reg;
            since_fire_reg <= item_reg.now_ms - rd_lf_reg;
        end
    end

    // Item capture and walk index.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            item_reg <= item_in;
        end
        if (cmd.start) begin
            idx_reg <= '0;
        end else if (cmd.eval && !status.eval_stall && !status.walk_end) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Control state: flags, resume time and the last checked minute.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            pend_reg      <= '0;
            needs_reg     <= '0;
            resume_ms_reg <= '0;
            chk_hour_reg  <= '0;
            chk_min_reg   <= '0;
        end else begin
            if (cmd.write && wr_in_range) begin
                valid_reg[wr_addr] <= 1'b1;
                pend_reg[wr_addr]  <= 1'b0;
                needs_reg[wr_addr] <= wr_needs;
            end
            if (cmd.start && !status.skip) begin
                if (is_tick && !need_sec) begin
                    chk_hour_reg <= item_reg.hour;
                    chk_min_reg  <= item_reg.minute;
                end
                if (is_resume) begin
                    resume_ms_reg <= item_reg.now_ms;
                end
            end
            if (cmd.eval && !status.eval_stall && live) begin
                if (res_wait) begin
                    pend_reg[idx_reg] <= 1'b1;
                end else if (pend_clr) begin
                    pend_reg[idx_reg] <= 1'b0;
                end
            end
        end
    end

    // Pending result: one firing is held until the next one or the walk end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (cmd.eval && fire && !status.eval_stall) begin
            hold_valid_reg <= 1'b1;
        end else if (push_flush) begin
            hold_valid_reg <= 1'b0;
        end
    end

    logic [WID_W-1:0] idx_wide;
    assign idx_wide = {4'd0, idx_reg};

    always_ff @(posedge aclk) begin
        if (cmd.eval && fire && !status.eval_stall) begin
            hold_idx_reg   <= idx_wide[3:0];
            hold_blink_reg <= e_opt[mea_pkg::OPT_BLINK];
            hold_bsec_reg  <= e_opt[mea_pkg::OPT_BLINK]
                              ? e_opt[mea_pkg::OPT_BLINKS_LO +: 16] : 16'd0;
            hold_snd_reg   <= e_opt[mea_pkg::OPT_SOUND];
            hold_loops_reg <= loops;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (push_eval || push_flush) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_eval || push_flush) begin
            out_idx_reg   <= hold_idx_reg;
            out_blink_reg <= hold_blink_reg;
            out_bsec_reg  <= hold_bsec_reg;
            out_snd_reg   <= hold_snd_reg;
            out_loops_reg <= hold_loops_reg;
            out_last_reg  <= push_flush;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_loops_reg, out_snd_reg, out_bsec_reg,
                       out_blink_reg, out_idx_reg};

endmodule

@@ rtl/core/multi_entry_alarm_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_entry_alarm_matcher
// Alarm table engine: entry writes load a slot, events walk the table and
// emit one result word per firing alarm.
// ----------------------------------------------------------------------------
// Sequence: an entry write is latched, checked and stored; an event is latched
//   and qualified, then each table entry is read, passed through the limit stage
//   and decided on, and a final flush emits the last held result.
// Throughput: one word at a time, set by the single shared evaluation unit.
//   A stalled port holds the walk at a firing entry or the flush if one is held.
// Reset: all slots invalid, no resume pending, times zero; slot contents are
//   undefined until written.
module multi_entry_alarm_matcher #(
    parameter int ALARM_ENTRIES = mea_pkg::ALARM_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // hour[4:0], minute[10:5], second[16:11], weekday[19:17], now_ms[51:20],
    // entry_index[55:52], hour_mask[79:56], minute_mask[139:80],
    // weekday_mask[146:140], match_second[152:147], entry_options[209:153]
    input  logic [215:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // alarm_index[3:0], blink_request[4], blink_seconds[20:5],
    // play_sound[21], loop_count[27:22]
    output logic [31:0]  m_tdata,
    output logic         m_tlast
);

    mea_pkg::item_t   item;
    mea_pkg::cmd_t    cmd;
    mea_pkg::status_t status;

    // Unpack the input word.
    always_comb begin
        item.kind          = s_tuser;
        item.hour          = s_tdata[4:0];
        item.minute        = s_tdata[10:5];
        item.second        = s_tdata[16:11];
        item.weekday       = s_tdata[19:17];
        item.now_ms        = s_tdata[51:20];
        item.entry_index   = s_tdata[55:52];
        item.hour_mask     = s_tdata[79:56];
        item.minute_mask   = s_tdata[139:80];
        item.weekday_mask  = s_tdata[146:140];
        item.match_second  = s_tdata[152:147];
        item.entry_options = s_tdata[209:153];
    end

    mea_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mea_datapath #(
        .ALARM_ENTRIES (ALARM_ENTRIES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item_in  (item),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A new word is taken only with no firing left pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !status.hold_valid)
        else $error("input ready while a result is pending");

    // One word at a time: no acceptance in the cycle after one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("two words accepted back to back");

    // The controller issues at most one command per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.latch, cmd.write, cmd.start, cmd.read, cmd.mul,
                  cmd.eval, cmd.flush}))
        else $error("overlapping controller commands");

endmodule
